### sv/pgp_rsa_pubkey_mpi_extractor_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the OpenPGP RSA public-key MPI extractor
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef PGP_RSA_PUBKEY_MPI_EXTRACTOR_UNIT_MACROS_SVH
`define PGP_RSA_PUBKEY_MPI_EXTRACTOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define PGPRSA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PGPRSA_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define PGPRSA_ASSERT(lbl, clk, rst_n, prop, msg)
`define PGPRSA_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

### sv/pgprsa_pkg.sv
// ----------------------------------------------------------------------------
// OpenPGP RSA public-key MPI extractor package
// Parse phases, error codes, tag masks and the records passed between stages.
// ----------------------------------------------------------------------------
package pgprsa_pkg;

  typedef enum logic [3:0] {
    PH_TAG     = 4'd0,
    PH_HDR     = 4'd1,
    PH_VERSION = 4'd2,
    PH_CTIME   = 4'd3,
    PH_ALGO    = 4'd4,
    PH_LEN_HI  = 4'd5,
    PH_LEN_LO  = 4'd6,
    PH_BODY    = 4'd7,
    PH_DONE    = 4'd8,
    PH_ERROR   = 4'd9
  } pgprsa_phase_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_NOT_PGP    = 3'd1,
    ERR_NEW_HDR    = 3'd2,
    ERR_NOT_PUBKEY = 3'd3,
    ERR_INDEF      = 3'd4,
    ERR_VERSION    = 3'd5,
    ERR_NOT_RSA    = 3'd6,
    ERR_TOO_LONG   = 3'd7
  } pgprsa_err_e;

  localparam logic [7:0]  TAG_MARK_MASK = 8'h80;
  localparam logic [7:0]  TAG_NEW_MASK  = 8'h40;
  localparam logic [7:0]  TAG_TYPE_MASK = 8'h18;
  localparam logic [1:0]  LEN_TYPE_INDEF = 2'd3;
  localparam logic [7:0]  PGP_VERSION = 8'd4;
  localparam logic [7:0]  ALGO_RSA = 8'd1;
  localparam logic [7:0]  ALGO_RSA_SIGN = 8'd3;
  localparam logic [2:0]  CTIME_BYTES = 3'd4;
  localparam logic [13:0] MAX_MPI_RESET = 14'd512;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       restart;
  } pgprsa_in_t;

  typedef struct packed {
    logic        key_valid;
    logic        which_key;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [13:0] key_length;
    logic [2:0]  error_code;
    logic        done_res;
  } pgprsa_res_t;

endpackage

### sv/pgprsa_in_stage.sv
// ----------------------------------------------------------------------------
// Input register stage
// Holds one accepted byte until the parse stage consumes it.
// ----------------------------------------------------------------------------
module pgprsa_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  pgprsa_pkg::pgprsa_in_t data_i,
  output logic                valid_o,
  input  logic                take_i,
  output pgprsa_pkg::pgprsa_in_t data_o
);
  import pgprsa_pkg::*;

  logic       valid_q;
  logic       valid_d;
  pgprsa_in_t data_q;

  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### sv/pgprsa_parse.sv
// ----------------------------------------------------------------------------
// Packet parse stage
// Holds the parse state and the size limit, and works out one result per byte.
// ----------------------------------------------------------------------------
`include "pgp_rsa_pubkey_mpi_extractor_unit_macros.svh"

module pgprsa_parse (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [13:0]           cfg_wdata_i,
  input  logic                  fire_i,
  input  pgprsa_pkg::pgprsa_in_t  item_i,
  output pgprsa_pkg::pgprsa_res_t res_o
);
  import pgprsa_pkg::*;

  pgprsa_phase_e phase_q, phase_d, phase_c;
  logic [2:0]  skip_q, skip_d, skip_c, skip_dec;
  logic [13:0] body_q, body_d, body_c, body_dec;
  logic [7:0]  len_hi_q, len_hi_d, len_hi_c;
  logic        key_q, key_d, key_c;
  logic [13:0] count_q, count_d, count_c, count_inc;
  logic [2:0]  err_q, err_d, err_c;
  logic [13:0] max_q;

  logic [7:0]  b;
  logic [16:0] bytes_sum;
  logic [13:0] bytes;
  logic        too_long;
  logic [1:0]  len_type;

  assign b        = item_i.byte_in;
  assign len_type = b[1:0];

  always_comb begin
    if (item_i.restart) begin
      phase_c  = PH_TAG;
      skip_c   = '0;
      body_c   = '0;
      len_hi_c = '0;
      key_c    = 1'b0;
      count_c  = '0;
      err_c    = ERR_NONE;
    end else begin
      phase_c  = phase_q;
      skip_c   = skip_q;
      body_c   = body_q;
      len_hi_c = len_hi_q;
      key_c    = key_q;
      count_c  = count_q;
      err_c    = err_q;
    end
  end

  assign skip_dec  = (skip_c != 3'd0) ? skip_c - 3'd1 : 3'd0;
  assign body_dec  = (body_c != 14'd0) ? body_c - 14'd1 : 14'd0;
  assign count_inc = count_c + 14'd1;
  assign bytes_sum = {1'b0, len_hi_c, b} + 17'd7;
  assign bytes     = bytes_sum[16:3];
  assign too_long  = bytes > max_q;

  // Next state.
  always_comb begin
    phase_d  = phase_c;
    skip_d   = skip_c;
    body_d   = body_c;
    len_hi_d = len_hi_c;
    key_d    = key_c;
    count_d  = count_c;
    err_d    = err_c;
    case (phase_c)
      PH_TAG: begin
        phase_d = PH_ERROR;
        if ((b & TAG_MARK_MASK) == 8'd0) begin
          err_d = ERR_NOT_PGP;
        end else if ((b & TAG_NEW_MASK) != 8'd0) begin
          err_d = ERR_NEW_HDR;
        end else if ((b & TAG_TYPE_MASK) == 8'd0) begin
          err_d = ERR_NOT_PUBKEY;
        end else if (len_type == LEN_TYPE_INDEF) begin
          err_d = ERR_INDEF;
        end else begin
          phase_d = PH_HDR;
          case (len_type)
            2'd0:    skip_d = 3'd1;
            2'd1:    skip_d = 3'd2;
            default: skip_d = 3'd4;
          endcase
        end
      end
      PH_HDR: begin
        skip_d = skip_dec;
        if (skip_dec == 3'd0) begin
          phase_d = PH_VERSION;
        end
      end
      PH_VERSION: begin
        if (b != PGP_VERSION) begin
          err_d   = ERR_VERSION;
          phase_d = PH_ERROR;
        end else begin
          skip_d  = CTIME_BYTES;
          phase_d = PH_CTIME;
        end
      end
      PH_CTIME: begin
        skip_d = skip_dec;
        if (skip_dec == 3'd0) begin
          phase_d = PH_ALGO;
        end
      end
      PH_ALGO: begin
        if (b != ALGO_RSA && b != ALGO_RSA_SIGN) begin
          err_d   = ERR_NOT_RSA;
          phase_d = PH_ERROR;
        end else begin
          key_d   = 1'b0;
          count_d = '0;
          phase_d = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        len_hi_d = b;
        count_d  = 14'd1;
        phase_d  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (too_long) begin
          err_d   = ERR_TOO_LONG;
          phase_d = PH_ERROR;
        end else begin
          count_d = 14'd2;
          body_d  = bytes;
          if (bytes == 14'd0) begin
            if (!key_c) begin
              key_d   = 1'b1;
              count_d = '0;
              phase_d = PH_LEN_HI;
            end else begin
              phase_d = PH_DONE;
            end
          end else begin
            phase_d = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        count_d = count_inc;
        body_d  = body_dec;
        if (body_dec == 14'd0) begin
          if (!key_c) begin
            key_d   = 1'b1;
            count_d = '0;
            phase_d = PH_LEN_HI;
          end else begin
            phase_d = PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result fields.
  always_comb begin
    res_o            = '0;
    res_o.error_code = err_d;
    res_o.done_res   = (phase_d == PH_DONE);
    case (phase_c)
      PH_LEN_HI: begin
        res_o.key_valid  = 1'b1;
        res_o.key_length = 14'd1;
      end
      PH_LEN_LO: begin
        res_o.key_valid  = !too_long;
        res_o.key_last   = !too_long && (bytes == 14'd0);
        res_o.key_length = too_long ? 14'd0 : 14'd2;
      end
      PH_BODY: begin
        res_o.key_valid  = 1'b1;
        res_o.key_last   = (body_dec == 14'd0);
        res_o.key_length = count_inc;
      end
      default: begin
      end
    endcase
    if (res_o.key_valid) begin
      res_o.which_key = key_c;
      res_o.key_byte  = b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TAG;
      skip_q   <= '0;
      body_q   <= '0;
      len_hi_q <= '0;
      key_q    <= 1'b0;
      count_q  <= '0;
      err_q    <= ERR_NONE;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      skip_q   <= skip_d;
      body_q   <= body_d;
      len_hi_q <= len_hi_d;
      key_q    <= key_d;
      count_q  <= count_d;
      err_q    <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_MPI_RESET;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  `PGPRSA_ASSERT(a_error_has_code, clk_i, rst_ni, phase_q == PH_ERROR |-> err_q != ERR_NONE, "error phase without an error code")
  `PGPRSA_ASSERT(a_done_no_error, clk_i, rst_ni, phase_q == PH_DONE |-> err_q == ERR_NONE, "done phase with an error code")
  `PGPRSA_ASSERT(a_body_nonzero, clk_i, rst_ni, phase_q == PH_BODY |-> body_q != 14'd0, "body phase with no bytes left")
  `PGPRSA_ASSERT(a_last_is_valid, clk_i, rst_ni, fire_i && res_o.key_last |-> res_o.key_valid, "last flag on a byte that is not part of an MPI")
  `PGPRSA_ASSERT_NEXT(a_exp_end_done, clk_i, rst_ni, fire_i && res_o.key_last && res_o.which_key, phase_q == PH_DONE, "end of exponent did not finish the key")

endmodule

### sv/pgprsa_out_stage.sv
// ----------------------------------------------------------------------------
// Result register stage
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module pgprsa_out_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  output logic                  free_o,
  input  pgprsa_pkg::pgprsa_res_t res_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output pgprsa_pkg::pgprsa_res_t res_o
);
  import pgprsa_pkg::*;

  logic        valid_q;
  logic        valid_d;
  pgprsa_res_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

### sv/pgp_rsa_pubkey_mpi_extractor_unit.sv
// A byte accepted on the slave side passes the input register and the result register, then shows
// on the master side. Throughput: one byte per cycle while the master side takes results,
// set by the parse step on the state registers.
// Reset (rst_ni low, asynchronous): parse goes to expect-tag, both stages empty, limit 512.
// ----------------------------------------------------------------------------
// OpenPGP RSA public-key MPI extractor
// Parses an old-format public-key packet byte by byte and passes out n and e.
// ----------------------------------------------------------------------------
module pgp_rsa_pubkey_mpi_extractor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [13:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tuser,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] key_byte, [21:8] key_length,
                                      // [24:22] error_code, [25] done_res
  output logic [1:0]  m_axis_tuser,   // [0] key_valid, [1] which_key
  output logic        m_axis_tlast    // key_last
);
  import pgprsa_pkg::*;

  pgprsa_in_t  in_item;
  pgprsa_in_t  stage_item;
  pgprsa_res_t parse_res;
  pgprsa_res_t out_res;
  logic        stage_valid;
  logic        out_free;
  logic        fire;

  assign in_item.byte_in = s_axis_tdata;
  assign in_item.restart = s_axis_tuser;
  assign fire = stage_valid && out_free;

  pgprsa_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (in_item),
    .valid_o (stage_valid),
    .take_i  (out_free),
    .data_o  (stage_item)
  );

  pgprsa_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (stage_item),
    .res_o       (parse_res)
  );

  pgprsa_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .free_o  (out_free),
    .res_i   (parse_res),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  assign m_axis_tdata = {6'd0, out_res.done_res, out_res.error_code,
                         out_res.key_length, out_res.key_byte};
  assign m_axis_tuser = {out_res.which_key, out_res.key_valid};
  assign m_axis_tlast = out_res.key_last;

endmodule

### tb/pgp_rsa_pubkey_mpi_extractor_unit_test.sv
// ----------------------------------------------------------------------------
// Testbench for the OpenPGP RSA public-key MPI extractor
// Drives public-key packets byte by byte, some well-formed and some broken,
// under several idle patterns and limit settings. Every result transfer is
// checked field by field against a listed value or an in-bench parser model.
// ----------------------------------------------------------------------------
module pgp_rsa_pubkey_mpi_extractor_unit_test;
  import pgprsa_pkg::*;

  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_ITEMS  = 120;
  localparam int unsigned BODY_CAP     = 300;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned N_ROWS       = 31;

  typedef struct packed {
    logic [7:0]  data;
    logic        restart;
    logic        typed;
    pgprsa_res_t res;
  } key_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [13:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] byte_in
  logic        s_axis_tuser;   // [0] restart
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [7:0] key_byte, [21:8] key_length,
                               // [24:22] error_code, [25] done_res
  logic [1:0]  m_axis_tuser;   // [0] key_valid, [1] which_key
  logic        m_axis_tlast;   // key_last

  pgprsa_phase_e pk_phase;
  logic [2:0]    pk_skip;
  logic [13:0]   pk_body_left;
  logic [7:0]    pk_len_hi;
  logic          pk_key;
  logic [13:0]   pk_count;
  pgprsa_err_e   pk_err;
  logic [13:0]   mpi_limit;

  pgprsa_res_t mpi_bytes_due[$];
  pgprsa_res_t got_res;
  pgprsa_res_t want_res;
  key_row_t    key_rows [N_ROWS];
  int unsigned mismatches    = 0;
  int unsigned live_items    = 0;
  int unsigned stalled       = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_left     = 0;
  bit          hold_req      = 1'b0;

  pgp_rsa_pubkey_mpi_extractor_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_parse();
    pk_phase     = PH_TAG;
    pk_skip      = 3'd0;
    pk_body_left = 14'd0;
    pk_len_hi    = 8'd0;
    pk_key       = 1'b0;
    pk_count     = 14'd0;
    pk_err       = ERR_NONE;
  endfunction

  function automatic void flag_error(input pgprsa_err_e code);
    pk_err   = code;
    pk_phase = PH_ERROR;
  endfunction

  function automatic void end_mpi();
    if (!pk_key) begin
      pk_key   = 1'b1;
      pk_count = 14'd0;
      pk_phase = PH_LEN_HI;
    end else begin
      pk_phase = PH_DONE;
    end
  endfunction

  function automatic pgprsa_res_t key_res(input logic [7:0] b);
    pgprsa_res_t res;
    res            = '0;
    res.key_valid  = 1'b1;
    res.which_key  = pk_key;
    res.key_byte   = b;
    res.key_length = pk_count;
    return res;
  endfunction

  function automatic pgprsa_res_t quiet_res(input pgprsa_err_e code, input logic fin);
    pgprsa_res_t res;
    res            = '0;
    res.error_code = code;
    res.done_res   = fin;
    return res;
  endfunction

  function automatic pgprsa_res_t parse_key_byte(input logic [7:0] b, input logic rs);
    pgprsa_res_t res;
    int unsigned nbits;
    int unsigned nbytes;
    res = '0;
    if (rs) clear_parse();
    case (pk_phase)
      PH_TAG: begin
        if ((b & TAG_MARK_MASK) == 8'h00) flag_error(ERR_NOT_PGP);
        else if ((b & TAG_NEW_MASK) != 8'h00) flag_error(ERR_NEW_HDR);
        else if ((b & TAG_TYPE_MASK) == 8'h00) flag_error(ERR_NOT_PUBKEY);
        else if (b[1:0] == LEN_TYPE_INDEF) flag_error(ERR_INDEF);
        else begin
          pk_skip  = (b[1:0] == 2'd0) ? 3'd1 : (b[1:0] == 2'd1) ? 3'd2 : 3'd4;
          pk_phase = PH_HDR;
        end
      end
      PH_HDR: begin
        if (pk_skip != 3'd0) pk_skip = pk_skip - 3'd1;
        if (pk_skip == 3'd0) pk_phase = PH_VERSION;
      end
      PH_VERSION: begin
        if (b != PGP_VERSION) flag_error(ERR_VERSION);
        else begin
          pk_skip  = CTIME_BYTES;
          pk_phase = PH_CTIME;
        end
      end
      PH_CTIME: begin
        if (pk_skip != 3'd0) pk_skip = pk_skip - 3'd1;
        if (pk_skip == 3'd0) pk_phase = PH_ALGO;
      end
      PH_ALGO: begin
        if (b != ALGO_RSA && b != ALGO_RSA_SIGN) flag_error(ERR_NOT_RSA);
        else begin
          pk_key   = 1'b0;
          pk_count = 14'd0;
          pk_phase = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        pk_len_hi = b;
        pk_count  = 14'd1;
        res       = key_res(b);
        pk_phase  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        nbits  = 32'({pk_len_hi, b});
        nbytes = (nbits + 7) >> 3;
        if (nbytes > 32'(mpi_limit)) flag_error(ERR_TOO_LONG);
        else begin
          pk_count     = 14'd2;
          pk_body_left = 14'(nbytes);
          res          = key_res(b);
          if (pk_body_left == 14'd0) begin
            res.key_last = 1'b1;
            end_mpi();
          end else begin
            pk_phase = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        pk_count = pk_count + 14'd1;
        res      = key_res(b);
        if (pk_body_left != 14'd0) pk_body_left = pk_body_left - 14'd1;
        if (pk_body_left == 14'd0) begin
          res.key_last = 1'b1;
          end_mpi();
        end
      end
      default: ;
    endcase
    res.error_code = pk_err;
    res.done_res   = (pk_phase == PH_DONE);
    return res;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic rs, input logic typed,
                           input pgprsa_res_t want);
    pgprsa_res_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= rs;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (rs || (pk_phase != PH_ERROR && pk_phase != PH_DONE)) live_items++;
    pred = parse_key_byte(b, rs);
    mpi_bytes_due.push_back(typed ? want : pred);
    @(negedge clk_i);
  endtask

  task automatic push_noise(input logic rs);
    push_byte(8'($urandom_range(255)), rs, 1'b0, '0);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (mpi_bytes_due.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_mpi_limit(input logic [13:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    mpi_limit   = value;
  endtask

  task automatic send_mpi(input int forced_bits, input bit cut, output bit ok);
    int unsigned sel;
    int unsigned nbits;
    int unsigned nbytes;
    int unsigned sent;
    sel = $urandom_range(99);
    if (forced_bits >= 0) nbits = forced_bits;
    else if (sel < 8) nbits = 0;
    else if (sel < 55) nbits = $urandom_range(1, 255);
    else if (sel < 75) nbits = $urandom_range(256, 1023);
    else if (sel < 90) begin
      nbytes = 32'(mpi_limit) + $urandom_range(1);
      nbits  = (nbytes == 0) ? 0 : nbytes * 8 - $urandom_range(7);
      if (nbits > 65535) nbits = 65535;
    end else begin
      nbits = $urandom_range(65535);
    end
    nbytes = (nbits + 7) >> 3;
    push_byte(8'(nbits >> 8), 1'b0, 1'b0, '0);
    push_byte(8'(nbits), 1'b0, 1'b0, '0);
    ok = (nbytes <= 32'(mpi_limit));
    if (ok) begin
      sent = nbytes;
      if (forced_bits < 0 && (nbytes > BODY_CAP || (cut && nbytes != 0))) begin
        sent = $urandom_range((nbytes > BODY_CAP ? BODY_CAP : nbytes) - 1);
        ok   = 1'b0;
      end
      repeat (sent) push_noise(1'b0);
    end
  endtask

  // A packet may carry one deliberate flaw: a random tag, a bad version,
  // a bad algorithm, or an MPI cut short by the next packet's restart.
  task automatic send_key_packet(input bit head_only);
    int unsigned kind;
    int unsigned flaw;
    int unsigned hdr_len;
    logic [7:0]  tag;
    bit          ok;
    kind = $urandom_range(99);
    if (!head_only && kind < 10) begin
      repeat ($urandom_range(1, 6)) push_noise($urandom_range(3) == 0);
    end else begin
      flaw    = (!head_only && kind < 25) ? $urandom_range(1, 4) : 0;
      hdr_len = $urandom_range(2);
      tag = {1'b1, 1'b0, 1'($urandom_range(1)), 2'($urandom_range(1, 3)),
             1'($urandom_range(1)), 2'(hdr_len)};
      if (flaw == 1) tag = 8'($urandom_range(255));
      push_byte(tag, 1'b1, 1'b0, '0);
      repeat ((hdr_len == 0) ? 1 : (hdr_len == 1) ? 2 : 4) push_noise(1'b0);
      push_byte((flaw == 2) ? 8'($urandom_range(255)) : PGP_VERSION, 1'b0, 1'b0, '0);
      repeat (CTIME_BYTES) push_noise(1'b0);
      if (flaw == 3) push_noise(1'b0);
      else push_byte($urandom_range(1) ? ALGO_RSA : ALGO_RSA_SIGN, 1'b0, 1'b0, '0);
      if (!head_only) begin
        send_mpi(-1, flaw == 4, ok);
        if (ok) send_mpi(-1, flaw == 4, ok);
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) push_noise(1'b0);
      end
    end
  endtask

  task automatic report_mismatch(input string what, input pgprsa_res_t want,
                                 input pgprsa_res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected v=%0b k=%0b byte=%02h last=%0b len=%0d err=%0d done=%0b",
               $time, what, want.key_valid, want.which_key, want.key_byte, want.key_last,
               want.key_length, want.error_code, want.done_res);
      $display("    got v=%0b k=%0b byte=%02h last=%0b len=%0d err=%0d done=%0b",
               got.key_valid, got.which_key, got.key_byte, got.key_last,
               got.key_length, got.error_code, got.done_res);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stalled = 0;
      else stalled++;
      if (stalled >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else if (m_axis_tvalid && m_axis_tready) begin
        got_res.key_valid  = m_axis_tuser[0];
        got_res.which_key  = m_axis_tuser[1];
        got_res.key_byte   = m_axis_tdata[7:0];
        got_res.key_last   = m_axis_tlast;
        got_res.key_length = m_axis_tdata[21:8];
        got_res.error_code = m_axis_tdata[24:22];
        got_res.done_res   = m_axis_tdata[25];
        if (mpi_bytes_due.size() == 0) begin
          report_mismatch("result with nothing expected", '0, got_res);
        end else begin
          want_res = mpi_bytes_due.pop_front();
          if (got_res.key_valid !== want_res.key_valid ||
              got_res.which_key !== want_res.which_key ||
              got_res.key_byte !== want_res.key_byte ||
              got_res.key_last !== want_res.key_last ||
              got_res.key_length !== want_res.key_length ||
              got_res.error_code !== want_res.error_code ||
              got_res.done_res !== want_res.done_res) begin
            report_mismatch("result mismatch", want_res, got_res);
          end
        end
      end
    end
  end

  // The receiver holds off for a long stretch on request so the block fills up.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  initial begin
    logic [13:0] limit_v;
    int unsigned goal;
    bit          ok;
    bit          resume_mid;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 14'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tuser  = 1'b0;
    resume_mid    = 1'b0;
    mpi_limit     = MAX_MPI_RESET;
    clear_parse();

    key_rows = '{
      '{8'h7F, 1'b1, 1'b1, quiet_res(ERR_NOT_PGP, 1'b0)},
      '{8'hFF, 1'b1, 1'b1, quiet_res(ERR_NEW_HDR, 1'b0)},
      '{8'h80, 1'b1, 1'b1, quiet_res(ERR_NOT_PUBKEY, 1'b0)},
      '{8'h9B, 1'b1, 1'b1, quiet_res(ERR_INDEF, 1'b0)},
      '{8'h98, 1'b1, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b1, quiet_res(ERR_VERSION, 1'b0)},
      '{8'h98, 1'b1, 1'b0, '0},
      '{8'h55, 1'b0, 1'b0, '0},
      '{8'h04, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, quiet_res(ERR_NOT_RSA, 1'b0)},
      '{8'h9D, 1'b1, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'h04, 1'b0, 1'b0, '0},
      '{8'hA5, 1'b0, 1'b0, '0},
      '{8'h5A, 1'b0, 1'b0, '0},
      '{8'h0F, 1'b0, 1'b0, '0},
      '{8'hF0, 1'b0, 1'b0, '0},
      '{8'h03, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, '{1'b1, 1'b0, 8'h00, 1'b0, 14'd1, ERR_NONE, 1'b0}},
      '{8'h00, 1'b0, 1'b1, '{1'b1, 1'b0, 8'h00, 1'b1, 14'd2, ERR_NONE, 1'b0}},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h09, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hAB, 1'b0, 1'b1, quiet_res(ERR_NONE, 1'b1)}
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_ROWS; i++) begin
      push_byte(key_rows[i].data, key_rows[i].restart, key_rows[i].typed, key_rows[i].res);
    end

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: limit_v = 14'h3FFF;
        1: limit_v = 14'd0;
        2: limit_v = 14'd1;
        3: limit_v = MAX_MPI_RESET;
        4: limit_v = 14'd2;
        5: limit_v = 14'd8192;
        6: limit_v = 14'h2AAA;
        7: limit_v = 14'd40;
        8: limit_v = 14'h1555;
        default: limit_v = 14'($urandom_range(3, 64));
      endcase
      set_mpi_limit(limit_v);
      src_idle_pct  = (p % 4 == 1) ? 83 : (p % 4 == 3) ? 17 : 0;
      snk_stall_pct = (p % 4 == 2) ? 83 : (p % 4 == 3) ? 17 : 0;
      if (p == 0 || p == 4) hold_req = 1'b1;
      // The previous phase stopped just before the modulus length, so the
      // new limit applies to a parse already in progress.
      if (resume_mid) begin
        send_mpi(-1, 1'b0, ok);
        if (ok) send_mpi(-1, 1'b0, ok);
        resume_mid = 1'b0;
      end
      goal = live_items + PHASE_ITEMS;
      while (live_items < goal) send_key_packet(1'b0);
      if (p % 2 == 0) begin
        send_key_packet(1'b1);
        resume_mid = 1'b1;
      end
    end

    // One modulus of the largest size the limit allows, then a random exponent.
    set_mpi_limit(14'd64);
    src_idle_pct  = 17;
    snk_stall_pct = 17;
    send_key_packet(1'b1);
    send_mpi(512, 1'b0, ok);
    if (ok) send_mpi(-1, 1'b0, ok);

    s_axis_tvalid <= 1'b0;
    while (mpi_bytes_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
